FILE: sv/rhs_pkg.sv
// Shared constants, codes and types of the RGB histogram similarity block.
`default_nettype none
package rhs_pkg;

  localparam int BINS        = 256;
  localparam int COUNT_WIDTH = 24;
  localparam int CHANS       = 3;
  localparam int BANKS       = 2;

  localparam int AW     = $clog2(BINS);
  localparam int CW     = COUNT_WIDTH;
  localparam int TW     = CW + 2;            // per-bin R+G+B total
  localparam int HALF   = (TW + 1) / 2;      // low slice of a peak
  localparam int PW     = CW + TW;           // count times peak
  localparam int RW     = PW + 1;            // division remainder
  localparam int QW     = 16;                // quotient bits
  localparam int RTW    = QW + 1;            // ratio, Q0.16 plus the "equal" case
  localparam int SUM_W  = RTW + $clog2(CHANS * BINS) + 1;
  localparam int DIVW   = SUM_W - AW;        // sum divided by BINS
  localparam int RECW   = 18;
  localparam int RSH    = 19;                // shift of the divide-by-three
  localparam int SCORE_W = 17;

  localparam logic [RTW-1:0]  ONE_Q16 = RTW'(65536);
  localparam logic [RECW-1:0] RECIP3  = RECW'(174763);  // ceil(2^19 / 3)

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_PIXEL   = 2'd1;
  localparam logic [1:0] CMD_COMPARE = 2'd2;

  typedef struct packed {
    logic           done;
    logic [RTW-1:0] ratio;
  } lane_stat_t;

endpackage
`default_nettype wire

FILE: sv/rhs_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/rhs_lane.sv
// One channel lane: cross-multiplies a bin pair and divides min by max to Q0.16.
`default_nettype none
module rhs_lane (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [rhs_pkg::CW-1:0]  a,
  input  wire logic [rhs_pkg::CW-1:0]  b,
  input  wire logic [rhs_pkg::TW-1:0]  ma,
  input  wire logic [rhs_pkg::TW-1:0]  mb,
  output rhs_pkg::lane_stat_t          stat
);
  import rhs_pkg::*;

  typedef enum logic [5:0] {
    L_IDLE   = 6'b000001,
    L_MUL_LO = 6'b000010,
    L_MUL_HI = 6'b000100,
    L_CMP    = 6'b001000,
    L_DIV    = 6'b010000,
    L_DONE   = 6'b100000
  } lane_state_t;

  lane_state_t state;
  logic [CW-1:0]  a_r, b_r;
  logic [PW-1:0]  x, y, mx;
  logic [RW-1:0]  r;
  logic [QW-1:0]  q;
  logic [3:0]     cnt;
  logic [RTW-1:0] ratio;

  logic [CW+HALF-1:0]    px_lo, py_lo;
  logic [CW+TW-HALF-1:0] px_hi, py_hi;
  logic [RW-1:0]         r_shift;
  logic                  r_ge;
  logic [QW-1:0]         q_next;

  // partial products of a*mb and b*ma
  assign px_lo = a_r * mb[HALF-1:0];
  assign py_lo = b_r * ma[HALF-1:0];
  assign px_hi = a_r * mb[TW-1:HALF];
  assign py_hi = b_r * ma[TW-1:HALF];

  // one restoring division step
  assign r_shift = r << 1;
  assign r_ge    = r_shift >= RW'(mx);
  assign q_next  = {q[QW-2:0], r_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE, L_DONE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            state <= L_MUL_LO;
          end
        end
        L_MUL_LO: begin
          x     <= PW'(px_lo);
          y     <= PW'(py_lo);
          state <= L_MUL_HI;
        end
        L_MUL_HI: begin
          x     <= x + (PW'(px_hi) << HALF);
          y     <= y + (PW'(py_hi) << HALF);
          state <= L_CMP;
        end
        L_CMP: begin
          if (a_r == '0 || b_r == '0) begin
            ratio <= '0;
            state <= L_DONE;
          end else if (x == y) begin
            ratio <= ONE_Q16;
            state <= L_DONE;
          end else begin
            mx    <= (x > y) ? x : y;
            r     <= RW'((x > y) ? y : x);
            q     <= '0;
            cnt   <= '0;
            state <= L_DIV;
          end
        end
        L_DIV: begin
          r   <= r_ge ? r_shift - RW'(mx) : r_shift;
          q   <= q_next;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(QW - 1)) begin
            ratio <= RTW'(q_next);
            state <= L_DONE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign stat.done  = (state == L_DONE);
  assign stat.ratio = ratio;

endmodule
`default_nettype wire

FILE: sv/rgb_histogram_similarity_top.sv
// Top level: histogram store, command sequencer, three channel lanes and score merge.
`default_nettype none
// Two banks of red, green and blue 256-bin histograms live in six 256x24 RAMs,
// one per bank and channel. After reset the block clears all RAMs in one
// pass before it takes its first item. A pixel is accepted, read, and then
// written back with saturation. A clear writes one bin per cycle. A compare
// first scans all bins to find both bank peaks, then walks the 256 bins
// with three lanes (red, green, blue) side by side; each lane runs its
// multiply-low, multiply-high and compare states and, unless a count is
// zero or the products match, 16 divide steps, before the next bin is read.
// The score is held in an output register, so the next item can be taken
// while it waits.
module rgb_histogram_similarity_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 command,
  input  wire logic                       bank,
  input  wire logic [7:0]                 red,
  input  wire logic [7:0]                 green,
  input  wire logic [7:0]                 blue,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rhs_pkg::SCORE_W-1:0]     score
);
  import rhs_pkg::*;

  typedef enum logic [11:0] {
    S_INIT    = 12'b000000000001,
    S_IDLE    = 12'b000000000010,
    S_PIX_RD  = 12'b000000000100,
    S_PIX_WR  = 12'b000000001000,
    S_CLR     = 12'b000000010000,
    S_PK      = 12'b000000100000,
    S_PK_END  = 12'b000001000000,
    S_RT_RD   = 12'b000010000000,
    S_RT_ST   = 12'b000100000000,
    S_RT_WAIT = 12'b001000000000,
    S_SCALE   = 12'b010000000000,
    S_OUT     = 12'b100000000000
  } top_state_t;

  top_state_t state;
  logic [AW-1:0]  idx;
  logic           bnk;
  logic [AW-1:0]  color [CHANS];
  logic           pk_v;
  logic [TW-1:0]  peak [BANKS];
  logic [SUM_W-1:0] sum;
  logic [DIVW+RECW-1:0] prod;

  logic [AW-1:0]  raddr [CHANS];
  logic [AW-1:0]  waddr [CHANS];
  logic [CW-1:0]  rdata [BANKS][CHANS];
  logic [CW-1:0]  wdata [BANKS][CHANS];
  logic           we    [BANKS][CHANS];
  logic [TW-1:0]  total [BANKS];

  logic       lane_start;
  lane_stat_t lane_stat [CHANS];
  logic       lanes_done;
  logic       load_out;

  // histogram RAMs, one per bank and channel
  for (genvar bk = 0; bk < BANKS; bk++) begin : g_bank
    for (genvar ch = 0; ch < CHANS; ch++) begin : g_chan
      always_comb begin
        we[bk][ch]    = (state == S_INIT) ||
                        ((state == S_CLR || state == S_PIX_WR) && bnk == 1'(bk));
        wdata[bk][ch] = '0;
        if (state == S_PIX_WR) begin
          wdata[bk][ch] = (rdata[bk][ch] == '1) ? rdata[bk][ch] : rdata[bk][ch] + CW'(1);
        end
      end

      rhs_ram #(.WIDTH(CW), .DEPTH(BINS)) u_ram (
        .clk   (clk),
        .we    (we[bk][ch]),
        .waddr (waddr[ch]),
        .wdata (wdata[bk][ch]),
        .raddr (raddr[ch]),
        .rdata (rdata[bk][ch])
      );
    end

    // per-bin R+G+B total of the bank
    assign total[bk] = TW'(rdata[bk][0]) + TW'(rdata[bk][1]) + TW'(rdata[bk][2]);
  end

  // channel lanes
  for (genvar ch = 0; ch < CHANS; ch++) begin : g_lane
    assign raddr[ch] = (state == S_PIX_RD) ? color[ch] : idx;
    assign waddr[ch] = (state == S_PIX_WR) ? color[ch] : idx;

    rhs_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start),
      .a     (rdata[0][ch]),
      .b     (rdata[1][ch]),
      .ma    (peak[0]),
      .mb    (peak[1]),
      .stat  (lane_stat[ch])
    );
  end

  assign lane_start = (state == S_RT_ST);
  assign lanes_done = lane_stat[0].done && lane_stat[1].done && lane_stat[2].done;
  assign in_ready   = (state == S_IDLE);
  assign load_out   = (state == S_OUT) && (!out_valid || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
      pk_v  <= 1'b0;
    end else begin
      pk_v <= (state == S_PK);
      unique case (state)
        S_INIT, S_CLR: begin
          idx <= idx + AW'(1);
          if (idx == AW'(BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx <= '0;
          if (in_valid) begin
            bnk      <= bank;
            color[0] <= red;
            color[1] <= green;
            color[2] <= blue;
            case (command)
              CMD_CLEAR:   state <= S_CLR;
              CMD_PIXEL:   state <= S_PIX_RD;
              CMD_COMPARE: state <= S_PK;
              default:     state <= S_IDLE;
            endcase
          end
        end
        S_PIX_RD: state <= S_PIX_WR;
        S_PIX_WR: state <= S_IDLE;
        S_PK: begin
          idx <= idx + AW'(1);
          if (idx == AW'(BINS - 1)) begin
            state <= S_PK_END;
          end
        end
        S_PK_END:  state <= S_RT_RD;
        S_RT_RD:   state <= S_RT_ST;
        S_RT_ST:   state <= S_RT_WAIT;
        S_RT_WAIT: begin
          if (lanes_done) begin
            idx <= idx + AW'(1);
            state <= (idx == AW'(BINS - 1)) ? S_SCALE : S_RT_RD;
          end
        end
        S_SCALE: state <= S_OUT;
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // peaks and merged ratio sum
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      peak[0] <= '0;
      peak[1] <= '0;
      sum     <= '0;
    end
    if (pk_v) begin
      for (int bk = 0; bk < BANKS; bk++) begin
        if (total[bk] > peak[bk]) begin
          peak[bk] <= total[bk];
        end
      end
    end
    if (state == S_RT_WAIT && lanes_done) begin
      sum <= sum + SUM_W'(lane_stat[0].ratio) + SUM_W'(lane_stat[1].ratio)
                 + SUM_W'(lane_stat[2].ratio);
    end
    // divide by 3*BINS: shift right by log2(BINS), then multiply by the reciprocal of 3
    if (state == S_SCALE) begin
      prod <= sum[SUM_W-1:AW] * RECIP3;
    end
    if (load_out) begin
      score <= prod[RSH+SCORE_W-1:RSH];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // lanes are started only together and only when none is busy
  a_lane_start: assert property (@(posedge clk) disable iff (rst)
    lane_start |-> $past(state == S_RT_RD))
    else $error("lanes started outside a bin read");

  // a finished lane never reports more than one
  a_lane_ratio: assert property (@(posedge clk) disable iff (rst)
    lanes_done |-> (lane_stat[0].ratio <= ONE_Q16 && lane_stat[1].ratio <= ONE_Q16
                    && lane_stat[2].ratio <= ONE_Q16))
    else $error("lane ratio above one");

  // a delivered score stays within Q1.16 one
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> score <= SCORE_W'(65536))
    else $error("score above one");

  // the output register is loaded only when free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && state == S_OUT) |=> $stable(score))
    else $error("pending score overwritten");

endmodule
`default_nettype wire

FILE: verif/rgb_histogram_similarity_top_tb.sv
// Testbench for the RGB histogram similarity block: queued stimulus, score predictor, checker.
`timescale 1ns / 1ps
module rgb_histogram_similarity_top_tb;
  import rhs_pkg::*;

  typedef struct {
    logic [1:0] cmd;
    logic       bnk;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = CMD_CLEAR;
  logic bank = 1'b0;
  logic [7:0] red = 8'd0;
  logic [7:0] green = 8'd0;
  logic [7:0] blue = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SCORE_W-1:0] score;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  beat_t pending_beats[$];
  logic [SCORE_W-1:0] score_queue[$];
  logic [CW-1:0] counts [BANKS][CHANS][BINS];
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;

  rgb_histogram_similarity_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .bank(bank), .red(red), .green(green), .blue(blue),
    .out_valid(out_valid), .out_ready(out_ready), .score(score)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Mean of the bin-wise min/max ratios of both banks, each normalized by its peak.
  function automatic logic [SCORE_W-1:0] similarity();
    logic [63:0] peak [BANKS];
    logic [63:0] tot, sum;
    logic [127:0] x, y, mn, mx;
    peak[0] = 0;
    peak[1] = 0;
    sum = 0;
    for (int k = 0; k < BANKS; k++)
      for (int i = 0; i < BINS; i++) begin
        tot = 64'(counts[k][0][i]) + 64'(counts[k][1][i]) + 64'(counts[k][2][i]);
        if (tot > peak[k]) peak[k] = tot;
      end
    for (int c = 0; c < CHANS; c++)
      for (int i = 0; i < BINS; i++) begin
        if (counts[0][c][i] != 0 && counts[1][c][i] != 0) begin
          x = 128'(counts[0][c][i]) * 128'(peak[1]);
          y = 128'(counts[1][c][i]) * 128'(peak[0]);
          mn = (x < y) ? x : y;
          mx = (x < y) ? y : x;
          sum += 64'(((mn << 16) / mx));
        end
      end
    return SCORE_W'(sum / (CHANS * BINS));
  endfunction

  // Queue one beat and advance the histogram image.
  task automatic add_beat(input logic [1:0] c, input logic bk,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    beat_t t;
    t.cmd = c; t.bnk = bk; t.r = r; t.g = g; t.b = b;
    pending_beats.push_back(t);
    case (c)
      CMD_CLEAR: begin
        for (int ch = 0; ch < CHANS; ch++)
          for (int i = 0; i < BINS; i++) counts[bk][ch][i] = '0;
      end
      CMD_PIXEL: begin
        if (counts[bk][0][r] != '1) counts[bk][0][r]++;
        if (counts[bk][1][g] != '1) counts[bk][1][g]++;
        if (counts[bk][2][b] != '1) counts[bk][2][b]++;
      end
      CMD_COMPARE: score_queue.push_back(similarity());
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_color();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
  endfunction

  // Drive beats; hold payload until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) in_gap = pick_gap();
      if (in_gap > 0 || pending_beats.size() == 0) begin
        if (in_gap > 0) in_gap--;
        in_valid <= 1'b0;
      end else begin
        beat_t t;
        t = pending_beats.pop_front();
        in_valid <= 1'b1;
        command <= t.cmd;
        bank <= t.bnk;
        red <= t.r;
        green <= t.g;
        blue <= t.b;
      end
    end
  end

  // Check scores and stall the result side at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (score_queue.size() == 0) begin
          report($sformatf("unexpected score %0d", score));
        end else begin
          logic [SCORE_W-1:0] want;
          want = score_queue.pop_front();
          if (score !== want) report($sformatf("score %0d, expected %0d", score, want));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_gap = pick_gap();
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int n, ncmp, p;
    for (int k = 0; k < BANKS; k++)
      for (int c = 0; c < CHANS; c++)
        for (int i = 0; i < BINS; i++) counts[k][c][i] = '0;

    // Directed: empty banks, identical banks, extremes, unused code, compare bank bit.
    add_beat(CMD_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
    add_beat(CMD_PIXEL, 1'b0, 8'd0, 8'd255, 8'd170);
    add_beat(CMD_COMPARE, 1'b1, 8'd255, 8'd255, 8'd255);
    add_beat(CMD_PIXEL, 1'b1, 8'd0, 8'd255, 8'd170);
    add_beat(CMD_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
    add_beat(CMD_PIXEL, 1'b0, 8'd255, 8'd0, 8'd85);
    add_beat(CMD_PIXEL, 1'b1, 8'd255, 8'd0, 8'd85);
    add_beat(CMD_PIXEL, 1'b1, 8'd255, 8'd0, 8'd85);
    add_beat(CMD_UNUSED, 1'b1, 8'd255, 8'd255, 8'd255);
    add_beat(CMD_COMPARE, 1'b1, 8'd0, 8'd0, 8'd0);
    add_beat(CMD_CLEAR, 1'b1, 8'd255, 8'd255, 8'd255);
    add_beat(CMD_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);
    add_beat(CMD_CLEAR, 1'b0, 8'd0, 8'd0, 8'd0);
    add_beat(CMD_COMPARE, 1'b0, 8'd0, 8'd0, 8'd0);

    // Random: mostly pixels in overlapping color ranges, compares and clears now and then.
    n = 0;
    ncmp = 0;
    while (n < 950 || ncmp < 40) begin
      p = $urandom_range(0, 99);
      if (p < 3) begin
        add_beat(CMD_CLEAR, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        n++;
      end else if (p < 8) begin
        add_beat(CMD_COMPARE, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        n++;
        ncmp++;
      end else if (p < 10) begin
        add_beat(CMD_UNUSED, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        add_beat(CMD_PIXEL, 1'($urandom), pick_color(), pick_color(), pick_color());
        n++;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_beats.size() != 0 || in_valid || score_queue.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule
